// ===== hw/rtl/dsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants for the drone synth voice
// Sequencer steps, command/status structs, fixed-point gains and ROM polynomial.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam int PHASE_BITS_DEF     = 24;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int STEP_W  = 23;
  localparam int GAIN_W  = 16;
  localparam int DECAY_W = 24;
  localparam int ENV_W   = 24;
  localparam int SEED_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOLO_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNEASE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_COEFF  = 3'd5;

  localparam logic [GAIN_W-1:0] GLIDE_RESET = 16'd27;

  localparam int G_FIFTH    = 29491;
  localparam int G_OCTAVE   = 14418;
  localparam int G_TONE     = 20972;
  localparam int G_TREM_DC  = 47186;
  localparam int G_TREM_AC  = 18350;
  localparam int G_HISS     = 3604;
  localparam int G_UNITY    = 65536;
  localparam int GLIDE_RND  = 32768;
  localparam int NOISE_MID  = 262144;
  localparam int ENV_MIN    = 167;
  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

  localparam longint POLY_C0 = 1686629713;
  localparam longint POLY_C1 = 693598668;
  localparam longint POLY_C2 = 85569306;
  localparam longint POLY_C3 = 5026995;
  localparam longint POLY_C4 = 172273;

  typedef enum logic [4:0] {
    S_IDLE, S_G0, S_G1, S_G2, S_G3, S_G4, S_B2, S_W5, S_W8, S_M5, S_M8,
    S_PH, S_TA, S_TL, S_TS, S_TT, S_LC, S_NZ, S_N1, S_N2, S_N3, S_N4,
    S_S1, S_S2, S_S3, S_OUT
  } state_t;

  typedef struct packed {
    state_t step;
    logic   load_strike;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic strike_on;
  } stat_t;

endpackage

// ===== hw/rtl/dsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsv_ctrl: sequencer for the drone synth voice
// Runs one tick through the shared-multiplier schedule and owns the handshakes.
// ----------------------------------------------------------------------------
module dsv_ctrl
  import dsv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  in_mode,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;

  assign fire = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && !in_mode) state_nxt = S_G0;
      S_G0:  state_nxt = S_G1;
      S_G1:  state_nxt = S_G2;
      S_G2:  state_nxt = S_G3;
      S_G3:  state_nxt = S_G4;
      S_G4:  state_nxt = S_B2;
      S_B2:  state_nxt = S_W5;
      S_W5:  state_nxt = S_W8;
      S_W8:  state_nxt = S_M5;
      S_M5:  state_nxt = S_M8;
      S_M8:  state_nxt = S_PH;
      S_PH:  state_nxt = S_TA;
      S_TA:  state_nxt = S_TL;
      S_TL:  state_nxt = S_TS;
      S_TS:  state_nxt = S_TT;
      S_TT:  state_nxt = S_LC;
      S_LC:  state_nxt = S_NZ;
      S_NZ:  state_nxt = S_N1;
      S_N1:  state_nxt = S_N2;
      S_N2:  state_nxt = S_N3;
      S_N3:  state_nxt = S_N4;
      S_N4:  state_nxt = stat.strike_on ? S_S1 : S_OUT;
      S_S1:  state_nxt = S_S2;
      S_S2:  state_nxt = S_S3;
      S_S3:  state_nxt = S_OUT;
      S_OUT: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = (state_r == S_IDLE);
    cmd.step         = state_r;
    cmd.load_strike  = (state_r == S_IDLE) && in_tvalid && in_mode;
    cmd.load_out     = fire;
    out_valid_nxt    = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/dsv_datapath.sv =====
// ----------------------------------------------------------------------------
// dsv_datapath: voicing registers, phase accumulators, sine ROM and one
// shared registered multiplier, stepped by the sequencer's command.
// ----------------------------------------------------------------------------
module dsv_datapath
  import dsv_pkg::*;
#(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [STEP_W-1:0]     in_strike_step,
  input  logic [GAIN_W-1:0]     in_strike_amp,
  input  logic [DECAY_W-1:0]    in_strike_decay,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic signed [15:0]    sample,
  output logic                  clipped
);

  localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
  localparam int FRAC_S    = SAMPLE_BITS - 1;
  localparam int PW        = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = SAMPLE_BITS + 2;
  localparam int ACC_W     = SAMPLE_BITS + 3;
  localparam int Q_W       = ACC_W + 4;
  localparam int Q_SHL     = (SAMPLE_BITS >= 16) ? 0 : 16 - SAMPLE_BITS;
  localparam int Q_SHR     = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int NZ_SHL    = (SAMPLE_BITS >= 19) ? SAMPLE_BITS - 19 : 0;
  localparam int NZ_SHR    = (SAMPLE_BITS >= 19) ? 0 : 19 - SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t   rom;
    longint quarter, quad, r, xi, x, x2, t, y, v, amp;
    quarter = longint'(ROM_DEPTH) >>> 2;
    amp     = (longint'(1) <<< FRAC_S) - 1;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      quad = longint'(k) >>> (SINE_ADDR_BITS - 2);
      r    = longint'(k) & (quarter - 1);
      xi   = quad[0] ? quarter - r : r;
      x    = xi <<< (30 - (SINE_ADDR_BITS - 2));
      x2   = (x * x) >>> 30;
      t    = POLY_C4;
      t    = POLY_C3 - ((x2 * t) >>> 30);
      t    = POLY_C2 - ((x2 * t) >>> 30);
      t    = POLY_C1 - ((x2 * t) >>> 30);
      t    = POLY_C0 - ((x2 * t) >>> 30);
      y    = (x * t) >>> 30;
      v    = (y * amp + (longint'(1) <<< 29)) >>> 30;
      if (v > amp) v = amp;
      rom[k] = SAMPLE_BITS'(quad[1] ? -v : v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [STEP_W-1:0] root_step_r, trem_step_r;
  logic [GAIN_W-1:0] bright_r, level_r, unease_r, glide_r;
  logic [STEP_W-1:0] root_now_r, trem_now_r;
  logic [GAIN_W-1:0] bright_now_r, level_now_r, unease_now_r;
  logic [PHASE_BITS-1:0] ph_root_r, ph_fifth_r, ph_oct_r, ph_trem_r, ph_strike_r;
  logic [SEED_W-1:0]  seed_r;
  logic [STEP_W-1:0]  strike_step_r;
  logic [ENV_W-1:0]   env_r;
  logic [DECAY_W-1:0] decay_r;

  logic signed [SAMPLE_BITS-1:0] rom_q, s_root_r, s5_r, s8_r, st_r;
  logic [SINE_ADDR_BITS-1:0]     rom_addr;
  logic [GAIN_W-1:0]             bb_r, w5_r, w8_r;
  logic signed [SUM_W-1:0]       sum_r, t_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [15:0]            sample_r;
  logic                          clip_r;

  logic signed [MUL_A_W-1:0] mul_a, p16, p25, glide_inc, nz_a;
  logic signed [MUL_B_W-1:0] mul_b, trem_g;
  logic signed [PW-1:0]      prod_r;
  logic signed [19:0]        nz_v;
  logic signed [39:0]        nz_w;
  logic signed [Q_W-1:0]     q_w;
  logic [STEP_W:0]           fifth_inc;
  logic                      trem_on;

  assign p16       = MUL_A_W'(prod_r >>> 16);
  assign p25       = MUL_A_W'(prod_r >>> 25);
  assign glide_inc = MUL_A_W'((prod_r + PW'(GLIDE_RND)) >>> 16);
  assign trem_on   = (trem_now_r != '0);
  assign trem_g    = trem_on ? MUL_B_W'(G_TREM_DC) + MUL_B_W'(prod_r >>> FRAC_S)
                             : MUL_B_W'(G_UNITY);
  assign nz_v      = $signed({1'b0, seed_r[27:9]}) - 20'sd262144;
  assign nz_w      = (40'(nz_v) <<< NZ_SHL) >>> NZ_SHR;
  assign nz_a      = MUL_A_W'(nz_w);
  assign fifth_inc = {1'b0, root_now_r} + {2'b0, root_now_r[STEP_W-1:1]};
  assign q_w       = (Q_W'(acc_r) <<< Q_SHL) >>> Q_SHR;
  assign stat.strike_on = (env_r > ENV_W'(ENV_MIN));

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = ph_root_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
    unique case (cmd.step)
      S_G0: mul_a = MUL_A_W'($signed({1'b0, root_step_r}) - $signed({1'b0, root_now_r}));
      S_G1: mul_a = MUL_A_W'($signed({1'b0, bright_r}) - $signed({1'b0, bright_now_r}));
      S_G2: mul_a = MUL_A_W'($signed({1'b0, level_r}) - $signed({1'b0, level_now_r}));
      S_G3: mul_a = MUL_A_W'($signed({1'b0, trem_step_r}) - $signed({1'b0, trem_now_r}));
      S_G4: mul_a = MUL_A_W'($signed({1'b0, unease_r}) - $signed({1'b0, unease_now_r}));
      S_B2: begin mul_a = MUL_A_W'(bright_now_r); mul_b = MUL_B_W'(bright_now_r); end
      S_W5: begin mul_a = MUL_A_W'(G_FIFTH);  mul_b = MUL_B_W'(bright_now_r); end
      S_W8: begin mul_a = MUL_A_W'(G_OCTAVE); mul_b = MUL_B_W'(bb_r); end
      S_M5: begin mul_a = MUL_A_W'(s5_r); mul_b = MUL_B_W'(w5_r); end
      S_M8: begin mul_a = MUL_A_W'(s8_r); mul_b = MUL_B_W'(w8_r); end
      S_TA: begin mul_a = MUL_A_W'(sum_r); mul_b = MUL_B_W'(G_TONE); end
      S_TL: begin mul_a = p16; mul_b = MUL_B_W'(level_now_r); end
      S_TS: begin mul_a = MUL_A_W'(st_r); mul_b = MUL_B_W'(G_TREM_AC); end
      S_TT: begin mul_a = MUL_A_W'(t_r); mul_b = trem_g; end
      S_LC: begin mul_a = MUL_A_W'(seed_r); mul_b = MUL_B_W'(LCG_MUL); end
      S_N1: begin mul_a = nz_a; mul_b = MUL_B_W'(G_HISS); end
      S_N2: begin mul_a = p16; mul_b = MUL_B_W'(unease_now_r); end
      S_N3: begin mul_a = p16; mul_b = MUL_B_W'(level_now_r); end
      S_S1: begin mul_a = MUL_A_W'(rom_q); mul_b = MUL_B_W'(env_r); end
      S_S2: begin mul_a = MUL_A_W'(env_r); mul_b = MUL_B_W'(decay_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    if (cmd.step == S_G0 || cmd.step == S_G1 || cmd.step == S_G2 || cmd.step == S_G3 ||
        cmd.step == S_G4) begin
      mul_b = MUL_B_W'(glide_r);
    end
    priority case (cmd.step)
      S_G1:    rom_addr = ph_fifth_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
      S_G2:    rom_addr = ph_oct_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
      S_TA:    rom_addr = ph_trem_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
      S_N4:    rom_addr = ph_strike_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
      default: rom_addr = ph_root_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q  <= SINE_ROM[rom_addr];
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_step_r   <= '0;
      bright_r      <= '0;
      level_r       <= '0;
      trem_step_r   <= '0;
      unease_r      <= '0;
      glide_r       <= GLIDE_RESET;
      root_now_r    <= '0;
      bright_now_r  <= '0;
      level_now_r   <= '0;
      trem_now_r    <= '0;
      unease_now_r  <= '0;
      ph_root_r     <= '0;
      ph_fifth_r    <= '0;
      ph_oct_r      <= '0;
      ph_trem_r     <= '0;
      ph_strike_r   <= '0;
      seed_r        <= '0;
      strike_step_r <= '0;
      env_r         <= '0;
      decay_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROOT_STEP:    root_step_r <= cfg_data[STEP_W-1:0];
          REG_BRIGHTNESS:   bright_r    <= cfg_data[GAIN_W-1:0];
          REG_LEVEL:        level_r     <= cfg_data[GAIN_W-1:0];
          REG_TREMOLO_STEP: trem_step_r <= cfg_data[STEP_W-1:0];
          REG_UNEASE:       unease_r    <= cfg_data[GAIN_W-1:0];
          REG_GLIDE_COEFF:  glide_r     <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_strike) begin
        strike_step_r <= in_strike_step;
        env_r         <= {in_strike_amp, 8'd0};
        decay_r       <= in_strike_decay;
        ph_strike_r   <= '0;
      end
      unique case (cmd.step)
        S_G1: root_now_r   <= STEP_W'($signed({1'b0, root_now_r}) + glide_inc);
        S_G2: bright_now_r <= GAIN_W'($signed({1'b0, bright_now_r}) + glide_inc);
        S_G3: level_now_r  <= GAIN_W'($signed({1'b0, level_now_r}) + glide_inc);
        S_G4: trem_now_r   <= STEP_W'($signed({1'b0, trem_now_r}) + glide_inc);
        S_B2: unease_now_r <= GAIN_W'($signed({1'b0, unease_now_r}) + glide_inc);
        S_PH: begin
          ph_root_r  <= ph_root_r + PHASE_BITS'(root_now_r);
          ph_fifth_r <= ph_fifth_r + PHASE_BITS'(fifth_inc);
          ph_oct_r   <= ph_oct_r + PHASE_BITS'({root_now_r, 1'b0});
          if (trem_on) ph_trem_r <= ph_trem_r + PHASE_BITS'(trem_now_r);
        end
        S_NZ: seed_r <= prod_r[SEED_W-1:0] + LCG_ADD;
        S_S2: ph_strike_r <= ph_strike_r + PHASE_BITS'(strike_step_r);
        S_S3: env_r <= prod_r[2*ENV_W-1:ENV_W];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      S_G1: s_root_r <= rom_q;
      S_G2: s5_r     <= rom_q;
      S_G3: s8_r     <= rom_q;
      S_W5: bb_r     <= GAIN_W'(prod_r >>> 16);
      S_W8: w5_r     <= GAIN_W'(prod_r >>> 16);
      S_M5: w8_r     <= GAIN_W'(prod_r >>> 16);
      S_M8: sum_r    <= SUM_W'(s_root_r) + SUM_W'(p16);
      S_PH: sum_r    <= sum_r + SUM_W'(p16);
      S_TL: st_r     <= rom_q;
      S_TS: t_r      <= SUM_W'(p16);
      S_LC: acc_r    <= ACC_W'(p16);
      S_N4: acc_r    <= acc_r + ACC_W'(p16);
      S_S2: acc_r    <= acc_r + ACC_W'(p25);
      default: ;
    endcase
    if (cmd.load_out) begin
      if (q_w > Q_W'(32767)) begin
        sample_r <= 16'sh7FFF;
        clip_r   <= 1'b1;
      end else if (q_w < -Q_W'(32768)) begin
        sample_r <= -16'sh8000;
        clip_r   <= 1'b1;
      end else begin
        sample_r <= 16'(q_w);
        clip_r   <= 1'b0;
      end
    end
  end

  assign sample  = sample_r;
  assign clipped = clip_r;

endmodule

// ===== hw/rtl/drone_synth_voice_core.sv =====
// ----------------------------------------------------------------------------
// drone_synth_voice_core: additive drone voice with a decaying strike tone
// Tick beats give one Q1.15 sample; strike beats load the strike tone.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_      | slave     | tuser: mode; tdata: strike_step, strike_amp, strike_decay
//  out_     | master    | tdata: sample; tuser: clipped
//  cfg_     | write     | index 0..5: root_step, brightness, level, tremolo_step,
//           |           |   unease, glide_coeff
//
//  A strike beat is taken in S_IDLE and leaves the input ready. A tick beat
//  runs its steps, adding the strike steps while the strike envelope is live,
//  on the single shared multiplier that every product passes through in turn.
//  Synchronous active-low reset; no clearing pass.
//  A finished sample waits in the output register; a new beat is taken while it
//  waits, and the next sample holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module drone_synth_voice_core
  import dsv_pkg::*;
#(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,  // strike_step[22:0], strike_amp[38:23],
                                           // strike_decay[62:39], zero[63]
  input  logic                  in_tuser,  // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata, // sample
  output logic                  out_tuser  // clipped
);

  cmd_t  cmd;
  stat_t stat;
  logic signed [15:0] sample;

  dsv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dsv_datapath #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_strike_step  (in_tdata[22:0]),
    .in_strike_amp   (in_tdata[38:23]),
    .in_strike_decay (in_tdata[62:39]),
    .cmd             (cmd),
    .stat            (stat),
    .sample          (sample),
    .clipped         (out_tuser)
  );

  assign out_tdata = sample;

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> !in_tready)
    else $error("tick beat did not start the sequence");

  a_strike_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> in_tready)
    else $error("strike beat stalled the input");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load_out))
    else $error("result beat raised without a sample load");

endmodule
